// ===== hw/rtl/vmpc_pkg.sv =====
// Shared types, codes and constants for the valve motor position controller.
// No dependencies; every other file of the block imports this package.
package vmpc_pkg;

  // Command opcodes as carried on the input tuser field
  typedef enum logic [2:0] {
    OP_EYE_EDGE  = 3'd0,
    OP_SAMPLE    = 3'd1,
    OP_CHECK     = 3'd2,
    OP_STOP      = 3'd3,
    OP_CLOSE     = 3'd4,
    OP_OPEN      = 3'd5,
    OP_GOTO      = 3'd6,
    OP_CALIBRATE = 3'd7
  } op_t;

  // Bridge drive codes
  typedef enum logic [1:0] {
    DRV_STOP  = 2'd0,
    DRV_OPEN  = 2'd1,
    DRV_CLOSE = 2'd2
  } drv_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NONE        = 3'd0,
    ST_GOTO_OK     = 3'd1,
    ST_GOTO_REFUSE = 3'd2,
    ST_CALIBRATED  = 3'd3,
    ST_CAL_FAILED  = 3'd4,
    ST_BLOCKED     = 3'd5,
    ST_TARGET      = 3'd6
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_END_HYST     = 2'd0,
    REG_TRAVEL_LIMIT = 2'd1,
    REG_STALL_PULSES = 2'd2,
    REG_VALVE_MOUNT  = 2'd3
  } cfg_index_t;

  localparam logic [7:0]  HYST_RESET    = 8'd50;
  localparam logic [15:0] TRAVEL_RESET  = 16'd1000;
  localparam logic [3:0]  STALL_RESET   = 4'd3;
  localparam logic [15:0] SPAN_RESET    = 16'd760;
  localparam logic [7:0]  PCT_FULL      = 8'd100;
  localparam logic [7:0]  CAL_SPLIT     = 8'd50;
  localparam int          PCT_STEP      = 10;
  localparam logic [15:0] SPAN10_RESET  = 16'(SPAN_RESET / PCT_STEP);

  // Configuration registers as seen by the executor
  typedef struct packed {
    logic [7:0]  end_hysteresis;
    logic [15:0] travel_limit;
    logic [3:0]  stall_pulses;
    logic        valve_mounted;
  } cfg_t;

  // Classified command, one queue entry
  typedef struct packed {
    op_t        op;
    logic       eye;
    logic [4:0] pct_div10;
    logic       pct_full;
    logic       pct_zero;
    logic       close_first;
  } cmd_t;

  // Percent divided by ten: reciprocal multiply, exact for all 8-bit values
  function automatic logic [4:0] pct_div10(input logic [7:0] p);
    logic [15:0] prod;
    prod = 16'(p) * 16'd205;
    return prod[15:11];
  endfunction

  // Span divided by ten: reciprocal multiply, exact for all 16-bit values
  function automatic logic [15:0] span_div10(input logic [15:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd52429;
    return 16'(prod >> 19);
  endfunction

endpackage

// ===== hw/rtl/vmpc_front.sv =====
// Front end: classifies an input word into a queue entry.
// Depends on vmpc_pkg.
module vmpc_front (
  input  logic [2:0]     opcode,
  input  logic [7:0]     percent,
  input  logic           eye_level,
  output vmpc_pkg::cmd_t cmd
);
  import vmpc_pkg::*;

  // Pre-work the percent so the executor only has one multiply to do
  always_comb begin
    cmd.op          = op_t'(opcode);
    cmd.eye         = eye_level;
    cmd.pct_div10   = pct_div10(percent);
    cmd.pct_full    = (percent == PCT_FULL);
    cmd.pct_zero    = (percent == 8'd0);
    cmd.close_first = (percent > CAL_SPLIT);
  end

endmodule

// ===== hw/rtl/vmpc_queue.sv =====
// Two-entry queue between the front end and the executor.
// Depends on vmpc_pkg.
module vmpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vmpc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output vmpc_pkg::cmd_t head_cmd
);
  import vmpc_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entry[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/vmpc_back.sv =====
// Executor: motor position state, calibration sequence and result register.
// Depends on vmpc_pkg.
module vmpc_back #(
  parameter int POSITION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  vmpc_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  vmpc_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [55:0]    m_tdata
);
  import vmpc_pkg::*;

  localparam int P = POSITION_BITS;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  logic [P-1:0] pos, pos_next;
  logic [P-1:0] stop, stop_next;
  logic [P-1:0] span, span_next;
  logic [P-1:0] span10, span10_next;
  logic [P-1:0] last_check, last_check_next;
  logic [P-1:0] last_sample, last_sample_next;
  drv_t         drive, drive_next;
  phase_t       phase, phase_next;
  logic         close_first, close_first_next;
  status_t      status;

  logic [P-1:0] hyst;
  logic [P-1:0] travel;
  logic [P-1:0] stall;
  logic [P-1:0] span_cand;
  logic [P-1:0] moved;
  logic [P+4:0] goto_prod;
  logic         closing_phase;

  assign hyst    = {{(P-8){1'b0}}, cfg.end_hysteresis};
  assign travel  = cfg.travel_limit[P-1:0];
  assign stall   = {{(P-4){1'b0}}, cfg.stall_pulses};
  assign cmd_pop = cmd_valid && (!m_tvalid || m_tready);

  // span recorded at the end of the second calibration phase
  assign span_cand = close_first ? pos : (travel - pos);
  // goto target for percentages other than the end stops
  assign goto_prod = {{P{1'b0}}, cmd.pct_div10} * {5'b00000, span10};

  // one command step
  always_comb begin
    pos_next         = pos;
    stop_next        = stop;
    span_next        = span;
    span10_next      = span10;
    last_check_next  = last_check;
    last_sample_next = last_sample;
    drive_next       = drive;
    phase_next       = phase;
    close_first_next = close_first;
    status           = ST_NONE;
    closing_phase    = (phase == PH_FIRST) ? close_first : !close_first;
    moved            = closing_phase ? (last_sample - pos) : (pos - last_sample);

    if (cmd.op inside {OP_STOP, OP_CLOSE, OP_OPEN, OP_GOTO}) begin
      phase_next = PH_IDLE;
    end

    unique case (cmd.op)
      OP_EYE_EDGE: begin
        if (cmd.eye && drive == DRV_OPEN) begin
          pos_next = pos + P'(1);
          if (!(pos_next < stop)) begin
            drive_next = DRV_STOP;
            status     = ST_TARGET;
          end
        end else if (cmd.eye && drive == DRV_CLOSE) begin
          pos_next = pos - P'(1);
          if (!(pos_next > stop)) begin
            drive_next = DRV_STOP;
            status     = ST_TARGET;
          end
        end
      end
      OP_SAMPLE: begin
        if (phase != PH_IDLE) begin
          if (drive == DRV_STOP || !cfg.valve_mounted) begin
            phase_next = PH_IDLE;
            status     = ST_CAL_FAILED;
          end else if (moved > stall) begin
            last_sample_next = pos;
          end else if (phase == PH_FIRST) begin
            // first end reached: run toward the other end
            phase_next = PH_SECOND;
            if (close_first) begin
              pos_next         = '0;
              stop_next        = travel;
              drive_next       = DRV_OPEN;
              last_sample_next = '0;
            end else begin
              pos_next         = travel;
              stop_next        = '0;
              drive_next       = DRV_CLOSE;
              last_sample_next = travel;
            end
          end else begin
            // both ends seen: record span, then head for fully closed if the span is nonzero
            drive_next  = DRV_STOP;
            phase_next  = PH_IDLE;
            span_next   = span_cand;
            span10_next = P'(span_div10(16'(span_cand)));
            pos_next    = close_first ? pos : '0;
            status      = ST_CALIBRATED;
            if (span_cand != '0) begin
              stop_next = '0;
              pos_next  = pos_next + hyst;
              if (pos_next != '0) drive_next = DRV_CLOSE;
            end
          end
        end
      end
      OP_CHECK: begin
        if (phase == PH_IDLE && drive != DRV_STOP) begin
          if (pos == last_check) begin
            drive_next = DRV_STOP;
            status     = ST_BLOCKED;
          end else begin
            last_check_next = pos;
          end
        end
      end
      OP_STOP:  drive_next = DRV_STOP;
      OP_CLOSE: drive_next = DRV_CLOSE;
      OP_OPEN:  drive_next = DRV_OPEN;
      OP_GOTO: begin
        if (span == '0) begin
          status = ST_GOTO_REFUSE;
        end else begin
          status = ST_GOTO_OK;
          if (cmd.pct_full) begin
            stop_next = span + hyst;
          end else if (cmd.pct_zero) begin
            stop_next = '0;
            pos_next  = pos + hyst;
          end else begin
            stop_next = goto_prod[P-1:0];
          end
          if (pos_next > stop_next) begin
            drive_next = DRV_CLOSE;
          end else if (pos_next < stop_next) begin
            drive_next = DRV_OPEN;
          end
        end
      end
      OP_CALIBRATE: begin
        close_first_next = cmd.close_first;
        phase_next       = PH_FIRST;
        if (cmd.close_first) begin
          pos_next         = travel;
          stop_next        = '0;
          drive_next       = DRV_CLOSE;
          last_sample_next = travel;
        end else begin
          pos_next         = '0;
          stop_next        = travel;
          drive_next       = DRV_OPEN;
          last_sample_next = '0;
        end
      end
      default: ;
    endcase
  end

  // state registers and result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      stop        <= '0;
      span        <= SPAN_RESET[P-1:0];
      span10      <= SPAN10_RESET[P-1:0];
      last_check  <= '0;
      last_sample <= '0;
      drive       <= DRV_STOP;
      phase       <= PH_IDLE;
      close_first <= 1'b0;
      m_tvalid    <= 1'b0;
    end else if (cmd_pop) begin
      pos         <= pos_next;
      stop        <= stop_next;
      span        <= span_next;
      span10      <= span10_next;
      last_check  <= last_check_next;
      last_sample <= last_sample_next;
      drive       <= drive_next;
      phase       <= phase_next;
      close_first <= close_first_next;
      m_tvalid    <= 1'b1;
      m_tdata     <= {2'b00,
                      (phase_next != PH_IDLE),
                      status,
                      16'(span_next),
                      16'(stop_next),
                      16'(pos_next),
                      drive_next};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/valve_motor_position_control_top.sv =====
// Valve motor position controller top: vmpc_pkg, vmpc_front, vmpc_queue, vmpc_back.
// Throughput: one word per cycle while m_tready allows; a two-entry queue parts the front end from
// the executor, whose update sets the rate.
// Reset (rst, synchronous, active high) empties the queue and the result
// register and loads the position state and registers with their defaults.
module valve_motor_position_control_top #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] percent, [8] eye_level, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [1:0] direction, [17:2] position, [33:18] target,
                                 // [49:34] full_open, [52:50] status, [53] calibrating
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import vmpc_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic push;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.end_hysteresis <= HYST_RESET;
      cfg.travel_limit   <= TRAVEL_RESET;
      cfg.stall_pulses   <= STALL_RESET;
      cfg.valve_mounted  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_END_HYST:     cfg.end_hysteresis <= cfg_data[7:0];
        REG_TRAVEL_LIMIT: cfg.travel_limit   <= cfg_data;
        REG_STALL_PULSES: cfg.stall_pulses   <= cfg_data[3:0];
        REG_VALVE_MOUNT:  cfg.valve_mounted  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vmpc_front u_front (
    .opcode    (s_tuser),
    .percent   (s_tdata[7:0]),
    .eye_level (s_tdata[8]),
    .cmd       (front_cmd)
  );

  vmpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  vmpc_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== sim/motor_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the valve motor position controller testbench.
// Tracks the controller state from input, result and register traffic and
// compares every result word field by field. Depends on vmpc_pkg.
module motor_result_checker #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] percent, [8] eye_level
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // [1:0] direction, [17:2] position, [33:18] target,
                                 // [49:34] full_open, [52:50] status, [53] calibrating
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import vmpc_pkg::*;

  localparam logic [15:0] POS_MASK = 16'((32'd1 << POSITION_BITS) - 32'd1);

  typedef enum logic [1:0] {
    CAL_IDLE   = 2'd0,
    CAL_FIRST  = 2'd1,
    CAL_SECOND = 2'd2
  } cal_phase_t;

  // One result word, laid out as on m_tdata
  typedef struct packed {
    logic        calibrating;
    status_t     status;
    logic [15:0] full_open;
    logic [15:0] target;
    logic [15:0] position;
    drv_t        direction;
  } motor_word_t;

  // Mirrored registers
  logic [7:0]  hyst_q;
  logic [15:0] travel_q;
  logic [3:0]  stall_q;
  logic        mounted_q;

  // Mirrored controller state
  logic [15:0] pos_q, stop_q, span_q, check_pos_q, sample_pos_q;
  drv_t        drive_q;
  cal_phase_t  phase_q;
  logic        close_first_q;

  motor_word_t predicted_words[$];

  task automatic report_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, want, got);
    fail_count++;
  endtask

  // Goto: target from a percentage, end margin at 0 % and 100 %
  task automatic aim_at_percent(input logic [7:0] pct, output status_t st);
    logic [31:0] span_prod;
    if (span_q == 16'd0) begin
      st = ST_GOTO_REFUSE;
    end else begin
      if (pct == PCT_FULL) begin
        stop_q = (span_q + 16'(hyst_q)) & POS_MASK;
      end else if (pct == 8'd0) begin
        stop_q = 16'd0;
        pos_q = (pos_q + 16'(hyst_q)) & POS_MASK;
      end else begin
        span_prod = (pct / PCT_STEP) * (span_q / PCT_STEP);
        stop_q = span_prod[15:0] & POS_MASK;
      end
      if (pos_q > stop_q) drive_q = DRV_CLOSE;
      else if (pos_q < stop_q) drive_q = DRV_OPEN;
      st = ST_GOTO_OK;
    end
  endtask

  task automatic begin_open_phase;
    pos_q = 16'd0;
    stop_q = travel_q & POS_MASK;
    drive_q = DRV_OPEN;
    sample_pos_q = pos_q;
  endtask

  task automatic begin_close_phase;
    pos_q = travel_q & POS_MASK;
    stop_q = 16'd0;
    drive_q = DRV_CLOSE;
    sample_pos_q = pos_q;
  endtask

  // Registers, result comparison, then prediction of the accepted input word
  always @(posedge clk) begin
    motor_word_t got, want;
    status_t     st, goto_st;
    logic        closing;
    logic [15:0] moved;
    if (rst) begin
      hyst_q = HYST_RESET;
      travel_q = TRAVEL_RESET;
      stall_q = STALL_RESET;
      mounted_q = 1'b1;
      pos_q = 16'd0;
      stop_q = 16'd0;
      span_q = SPAN_RESET & POS_MASK;
      check_pos_q = 16'd0;
      sample_pos_q = 16'd0;
      drive_q = DRV_STOP;
      phase_q = CAL_IDLE;
      close_first_q = 1'b0;
      predicted_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_END_HYST:     hyst_q = cfg_data[7:0];
          REG_TRAVEL_LIMIT: travel_q = cfg_data;
          REG_STALL_PULSES: stall_q = cfg_data[3:0];
          default:          mounted_q = cfg_data[0];
        endcase
      end

      if (m_tvalid && m_tready) begin
        if (predicted_words.size() == 0) begin
          report_mismatch("result word with none outstanding", 16'd0, 16'd0);
        end else begin
          want = predicted_words.pop_front();
          got = motor_word_t'(m_tdata[53:0]);
          if (got.direction !== want.direction)
            report_mismatch("direction", want.direction, got.direction);
          if (got.position !== want.position)
            report_mismatch("position", want.position, got.position);
          if (got.target !== want.target)
            report_mismatch("target", want.target, got.target);
          if (got.full_open !== want.full_open)
            report_mismatch("full_open", want.full_open, got.full_open);
          if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
          if (got.calibrating !== want.calibrating)
            report_mismatch("calibrating", want.calibrating, got.calibrating);
          if (m_tdata[55:54] !== 2'b00)
            report_mismatch("padding", 16'd0, m_tdata[55:54]);
        end
      end

      if (s_tvalid && s_tready) begin
        st = ST_NONE;
        // motion commands drop a calibration silently
        if (s_tuser == OP_STOP || s_tuser == OP_CLOSE || s_tuser == OP_OPEN ||
            s_tuser == OP_GOTO)
          phase_q = CAL_IDLE;

        case (op_t'(s_tuser))
          OP_EYE_EDGE: begin
            if (s_tdata[8] && drive_q == DRV_OPEN) begin
              pos_q = (pos_q + 16'd1) & POS_MASK;
              if (!(pos_q < stop_q)) begin
                drive_q = DRV_STOP;
                st = ST_TARGET;
              end
            end else if (s_tdata[8] && drive_q == DRV_CLOSE) begin
              pos_q = (pos_q - 16'd1) & POS_MASK;
              if (!(pos_q > stop_q)) begin
                drive_q = DRV_STOP;
                st = ST_TARGET;
              end
            end
          end
          OP_SAMPLE: begin
            if (phase_q != CAL_IDLE) begin
              closing = (phase_q == CAL_FIRST) ? close_first_q : !close_first_q;
              if (drive_q == DRV_STOP || !mounted_q) begin
                phase_q = CAL_IDLE;
                st = ST_CAL_FAILED;
              end else begin
                moved = (closing ? sample_pos_q - pos_q : pos_q - sample_pos_q) & POS_MASK;
                if (moved > 16'(stall_q)) begin
                  sample_pos_q = pos_q;
                end else if (phase_q == CAL_FIRST) begin
                  // end reached: run the opposite direction
                  drive_q = DRV_STOP;
                  phase_q = CAL_SECOND;
                  if (close_first_q) begin_open_phase();
                  else begin_close_phase();
                end else begin
                  // second end reached: record the span and head for 0 %
                  drive_q = DRV_STOP;
                  if (close_first_q) begin
                    span_q = pos_q;
                  end else begin
                    span_q = (travel_q - pos_q) & POS_MASK;
                    pos_q = 16'd0;
                  end
                  phase_q = CAL_IDLE;
                  aim_at_percent(8'd0, goto_st);
                  st = ST_CALIBRATED;
                end
              end
            end
          end
          OP_CHECK: begin
            if (phase_q == CAL_IDLE && drive_q != DRV_STOP) begin
              if (pos_q == check_pos_q) begin
                drive_q = DRV_STOP;
                st = ST_BLOCKED;
              end else begin
                check_pos_q = pos_q;
              end
            end
          end
          OP_STOP:  drive_q = DRV_STOP;
          OP_CLOSE: drive_q = DRV_CLOSE;
          OP_OPEN:  drive_q = DRV_OPEN;
          OP_GOTO:  aim_at_percent(s_tdata[7:0], st);
          default: begin
            close_first_q = (s_tdata[7:0] > CAL_SPLIT);
            phase_q = CAL_FIRST;
            if (close_first_q) begin_close_phase();
            else begin_open_phase();
          end
        endcase

        want.direction = drive_q;
        want.position = pos_q;
        want.target = stop_q;
        want.full_open = span_q;
        want.status = st;
        want.calibrating = (phase_q != CAL_IDLE);
        predicted_words.push_back(want);
      end
    end
    pending <= predicted_words.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the valve motor position controller testbench: clock, reset,
// command and register stimulus and the verdict. Checking sits in
// motor_result_checker; depends on vmpc_pkg and the controller RTL.
module tb_top;
  import vmpc_pkg::*;

  localparam int RANDOM_WORDS = 1050;
  localparam int PHASE_WORDS  = 130;

  typedef enum {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;   // [7:0] percent, [8] eye_level, rest zero
  logic [2:0]  s_tuser = 3'd0;    // [2:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;           // [1:0] direction, [17:2] position, [33:18] target,
                                  // [49:34] full_open, [52:50] status, [53] calibrating
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;
  int          fail_count;
  int          pending;

  // sender pacing
  int          burst_left = 0;
  int          words_sent = 0;
  logic [3:0]  stall_now = STALL_RESET;

  // receiver pacing
  int          holds_asked = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          pattern_left = 0;
  rx_mode_t    pattern_mode = RX_ALWAYS;

  always #5 clk = ~clk;

  valve_motor_position_control_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  motor_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: changing stall patterns, long hold-offs on request
  always @(posedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left <= 300;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_mode <= rx_mode_t'($urandom_range(0, 3));
        pattern_left <= $urandom_range(8, 60);
      end else begin
        pattern_left <= pattern_left - 1;
      end
      case (pattern_mode)
        RX_ALWAYS: m_tready <= 1'b1;
        RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // One command word, in bursts with random gaps between them
  task automatic send_word(input op_t op, input logic [7:0] pct, input logic eye);
    int   gap;
    logic ready_seen;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, eye, pct};
    // ready is looked at mid-cycle, the word goes at the following edge
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
    words_sent++;
  endtask

  // Stop offering and wait until every result word is back
  task automatic wait_for_results;
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [7:0] hyst, input logic [15:0] travel,
                               input logic [3:0] stall, input logic mounted);
    write_reg(REG_END_HYST, 16'(hyst));
    write_reg(REG_TRAVEL_LIMIT, travel);
    write_reg(REG_STALL_PULSES, 16'(stall));
    write_reg(REG_VALVE_MOUNT, 16'(mounted));
    stall_now = stall;
  endtask

  // Run limit
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int         phase;
    int         next_phase_at;
    int         last_word;
    int         edges;
    int         ticks;
    int         pick;
    logic [7:0] pct;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on reset register values
    send_word(OP_EYE_EDGE, 8'd0, 1'b1);     // stopped: not counted
    send_word(OP_CHECK, 8'hFF, 1'b0);       // stopped: ignored
    send_word(OP_SAMPLE, 8'hAA, 1'b1);      // not calibrating: ignored
    send_word(OP_GOTO, PCT_FULL, 1'b0);     // full open plus end margin
    send_word(OP_EYE_EDGE, 8'd0, 1'b0);     // low level: not counted
    send_word(OP_EYE_EDGE, 8'h55, 1'b1);
    send_word(OP_CHECK, 8'd0, 1'b0);        // has moved
    send_word(OP_CHECK, 8'd0, 1'b0);        // no movement: blocked stop
    send_word(OP_OPEN, 8'd0, 1'b0);
    send_word(OP_CLOSE, 8'd0, 1'b0);
    send_word(OP_EYE_EDGE, 8'd0, 1'b1);     // reaches the target while closing
    send_word(OP_GOTO, 8'd0, 1'b1);         // 0 % pushes the position out
    send_word(OP_STOP, 8'd0, 1'b0);
    send_word(OP_GOTO, 8'hFF, 1'b0);        // above 100 %
    send_word(OP_CALIBRATE, CAL_SPLIT, 1'b0);
    send_word(OP_GOTO, 8'd5, 1'b0);         // drops calibration, target = position
    send_word(OP_CALIBRATE, CAL_SPLIT + 8'd1, 1'b0);
    send_word(OP_CALIBRATE, 8'd0, 1'b1);    // restart while calibrating
    send_word(OP_SAMPLE, 8'd0, 1'b0);       // no movement: second phase
    send_word(OP_SAMPLE, 8'd0, 1'b0);       // span zero, closing goto refused
    send_word(OP_GOTO, 8'd40, 1'b0);        // refused while uncalibrated
    wait_for_results;

    // No valve mounted
    set_registers(8'd0, 16'd2, 4'd0, 1'b0);
    send_word(OP_CALIBRATE, 8'hFF, 1'b1);
    send_word(OP_SAMPLE, 8'd0, 1'b1);
    wait_for_results;

    // End limit stops the motor during a calibration phase
    set_registers(8'hFF, 16'd2, 4'hF, 1'b1);
    send_word(OP_CALIBRATE, 8'd10, 1'b0);
    send_word(OP_EYE_EDGE, 8'd0, 1'b1);
    send_word(OP_EYE_EDGE, 8'd0, 1'b1);
    send_word(OP_SAMPLE, 8'd0, 1'b0);

    // Random part, in phases with fresh register settings
    phase = 0;
    next_phase_at = words_sent;
    last_word = words_sent + RANDOM_WORDS;
    while (words_sent < last_word) begin
      if (words_sent >= next_phase_at) begin
        wait_for_results;
        case (phase)
          0: set_registers(8'd0, 16'd0, 4'd0, 1'b1);
          1: set_registers(8'hFF, 16'hFFFF, 4'hF, 1'b1);
          2: set_registers(HYST_RESET, TRAVEL_RESET, STALL_RESET, 1'b0);
          default: set_registers(8'($urandom),
                                 ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 80))
                                                             : 16'($urandom_range(200, 3000)),
                                 4'($urandom_range(0, 6)), $urandom_range(0, 5) != 0);
        endcase
        // one long receiver hold-off while words keep coming
        if (phase == 4) holds_asked <= holds_asked + 1;
        phase++;
        next_phase_at = words_sent + PHASE_WORDS;
      end

      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // calibration: moving samples, then a stalled one, per phase
        send_word(OP_CALIBRATE, 8'($urandom), 1'($urandom));
        repeat (2) begin
          ticks = $urandom_range(0, 3);
          repeat (ticks) begin
            edges = int'(stall_now) + $urandom_range(1, 6);
            repeat (edges) send_word(OP_EYE_EDGE, 8'($urandom), $urandom_range(0, 9) != 0);
            send_word(OP_SAMPLE, 8'($urandom), 1'($urandom));
          end
          edges = $urandom_range(0, int'(stall_now));
          repeat (edges) send_word(OP_EYE_EDGE, 8'($urandom), 1'b1);
          send_word(OP_SAMPLE, 8'($urandom), 1'($urandom));
        end
        // let the drive head for 0 %
        edges = $urandom_range(0, 40);
        repeat (edges) begin
          send_word(OP_EYE_EDGE, 8'($urandom), 1'b1);
          if ($urandom_range(0, 7) == 0) send_word(OP_CHECK, 8'($urandom), 1'($urandom));
        end
      end else if (pick < 7) begin
        // goto, then eye pulses with occasional block checks
        case ($urandom_range(0, 9))
          0:       pct = 8'd0;
          1:       pct = PCT_FULL;
          2:       pct = 8'($urandom_range(101, 255));
          default: pct = 8'($urandom_range(1, 99));
        endcase
        send_word(OP_GOTO, pct, 1'($urandom));
        edges = $urandom_range(0, 60);
        repeat (edges) begin
          if ($urandom_range(0, 9) == 0)
            send_word(OP_CHECK, 8'($urandom), 1'($urandom));
          else
            send_word(OP_EYE_EDGE, 8'($urandom), $urandom_range(0, 7) != 0);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_word(OP_CHECK, 8'($urandom), 1'($urandom));
          send_word(OP_CHECK, 8'($urandom), 1'($urandom));
        end
      end else begin
        // noise: any command with any content
        repeat ($urandom_range(1, 8))
          send_word(op_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      end
    end

    wait_for_results;
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
